// ----- src/bbhp_pkg.sv -----
// ----------------------------------------------------------------------------
// bbhp_pkg
// Types and constants shared by the buffer barrier hazard planner.
// ----------------------------------------------------------------------------
package bbhp_pkg;

   typedef enum logic [2:0] {
      FUNC_ACCESS     = 3'd0,
      FUNC_TRACK      = 3'd1,
      FUNC_FORGET     = 3'd2,
      FUNC_INVALIDATE = 3'd3,
      FUNC_BATCH      = 3'd4,
      FUNC_CLEAR      = 3'd5
   } func_type;

   localparam logic [4:0] CONS_WR_STAGE  = 5'h03;
   localparam logic [6:0] CONS_WR_ACCESS = 7'h0A;
   localparam logic [4:0] REUSE_STAGE    = 5'h07;
   localparam logic [6:0] REUSE_ACCESS   = 7'h1F;

   typedef struct packed {
      logic [2:0] func;
      logic [3:0] buffer_index;
      logic [2:0] use_req;
      logic       end_of_plan;
   } req_type;

   typedef struct packed {
      logic        has_barrier;
      logic [3:0]  out_slot;
      logic [4:0]  src_stage;
      logic [6:0]  src_access;
      logic [4:0]  dst_stage;
      logic [6:0]  dst_access;
      logic        is_conservative;
      logic        last_of_plan;
      logic [31:0] emit_total;
      logic [31:0] cons_total;
      logic [31:0] elide_total;
   } rsp_type;

   typedef struct packed {
      logic [4:0] wr_stage;
      logic [6:0] wr_access;
      logic [4:0] rd_stages;
      logic [4:0] vis_stage;
      logic [6:0] vis_access;
   } hazard_type;

   // merged scope: write flag, access, stage
   typedef struct packed {
      logic       wr;
      logic [6:0] access;
      logic [4:0] stage;
   } scope_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_COUNT,
      ST_WALK,
      ST_CLOSE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture request word
      logic exec;     // apply captured word to state
      logic count;    // first pass: tally slot at walk pointer
      logic walk;     // second pass: update slot, present its barrier
      logic empty;    // present empty item
      logic finish;   // close plan
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic eop;       // captured access closes plan
      logic walk_last; // walk pointer at last merged slot
      logic walk_none; // nothing merged
      logic any;       // some barrier in this plan
      logic rsp_busy;  // output register occupied, not being taken
   } sts_type;

   function automatic scope_type use_to_scope(input logic [2:0] u);
      scope_type s;
      unique case (u)
         3'd0: s = '{1'b0, 7'h01, 5'h01};
         3'd1: s = '{1'b1, 7'h02, 5'h01};
         3'd2: s = '{1'b1, 7'h03, 5'h01};
         3'd3: s = '{1'b0, 7'h04, 5'h02};
         3'd4: s = '{1'b1, 7'h08, 5'h02};
         3'd5: s = '{1'b0, 7'h10, 5'h04};
         3'd6: s = '{1'b0, 7'h20, 5'h08};
         default: s = '{1'b0, 7'h40, 5'h10};
      endcase
      return s;
   endfunction

endpackage

// ----- src/bbhp_datapath.sv -----
// ----------------------------------------------------------------------------
// bbhp_datapath
// Slot state, plan merge store, hazard check and result register.
// ----------------------------------------------------------------------------
module bbhp_datapath #(
   parameter int NUM_SLOTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  bbhp_pkg::req_type req_word,
   input  bbhp_pkg::cmd_type cmd,
   output bbhp_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bbhp_pkg::rsp_type rsp_word
);
   import bbhp_pkg::*;

   localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW = $clog2(NUM_SLOTS + 1);

   req_type    req_ff;
   logic [NUM_SLOTS-1:0] tracked_ff, force_ff, seen_ff;
   hazard_type haz_ff [NUM_SLOTS];
   scope_type  scope_ff [NUM_SLOTS];
   logic [3:0] order_ff [NUM_SLOTS];
   logic [CW-1:0] count_ff;
   logic [CW-1:0] ptr_ff;
   logic [CW-1:0] left_ff;   // barriers of this plan not yet presented
   logic [31:0] emitted_ff, fallback_ff, elided_ff;
   logic        any_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic        ok;
   logic [IW-1:0] ix;
   scope_type   us;
   logic [3:0]  ws;
   logic [IW-1:0] wix;
   scope_type   m;
   hazard_type  h, h_new;
   logic        cons, emit;
   logic [4:0]  ss;
   logic [6:0]  sa;
   logic        hw;
   logic        at_last;
   logic        put;

   assign ok      = {28'd0, req_ff.buffer_index} < 32'(NUM_SLOTS);
   assign ix      = IW'(req_ff.buffer_index);
   assign us      = use_to_scope(req_ff.use_req);
   assign ws      = order_ff[ptr_ff[IW-1:0]];
   assign wix     = IW'(ws);
   assign m       = scope_ff[wix];
   assign h       = haz_ff[wix];
   assign at_last = (ptr_ff + 1'b1) >= count_ff;
   assign put     = cmd.walk && emit;

   always_comb begin
      cons  = !tracked_ff[wix] || force_ff[wix];
      hw    = (h.wr_stage != '0) || (h.wr_access != '0);
      emit  = 1'b0;
      ss    = '0;
      sa    = '0;
      h_new = h;
      if (cons) begin
         emit  = 1'b1;
         ss    = CONS_WR_STAGE;
         sa    = CONS_WR_ACCESS;
         h_new = '0;
         if (tracked_ff[wix]) begin
            if (m.wr) begin
               h_new.wr_stage  = m.stage;
               h_new.wr_access = m.access;
            end else begin
               h_new.wr_stage   = CONS_WR_STAGE;
               h_new.wr_access  = CONS_WR_ACCESS;
               h_new.vis_stage  = m.stage;
               h_new.vis_access = m.access;
               h_new.rd_stages  = m.stage;
            end
         end
      end else if (!m.wr) begin
         if (hw && (((m.stage & ~h.vis_stage) != '0) ||
                    ((m.access & ~h.vis_access) != '0))) begin
            emit = 1'b1;
            ss   = h.wr_stage;
            sa   = h.wr_access;
            h_new.vis_stage  = h.vis_stage | m.stage;
            h_new.vis_access = h.vis_access | m.access;
         end
         h_new.rd_stages = h.rd_stages | m.stage;
      end else begin
         if (hw) begin
            emit = 1'b1;
            ss   = h.wr_stage | h.rd_stages;
            sa   = h.wr_access;
         end else if (h.rd_stages != '0) begin
            emit = 1'b1;
            ss   = h.rd_stages;
         end
         h_new = '{m.stage, m.access, 5'd0, 5'd0, 7'd0};
      end
   end

   // merge store, no reset
   always_ff @(posedge clock) begin
      if (cmd.exec && req_ff.func == FUNC_ACCESS && ok) begin
         if (!seen_ff[ix]) begin
            scope_ff[ix] <= us;
            if (count_ff < CW'(NUM_SLOTS)) order_ff[count_ff[IW-1:0]] <= req_ff.buffer_index;
         end else begin
            scope_ff[ix] <= scope_ff[ix] | us;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_word;
   end

   // count pass tallies the plan without touching slot state; walk pass
   // repeats the same decisions, updates state and presents the barriers
   always_ff @(posedge clock) begin
      if (reset || (cmd.exec && req_ff.func == FUNC_CLEAR)) begin
         tracked_ff  <= '0;
         force_ff    <= '0;
         seen_ff     <= '0;
         count_ff    <= '0;
         ptr_ff      <= '0;
         left_ff     <= '0;
         emitted_ff  <= '0;
         fallback_ff <= '0;
         elided_ff   <= '0;
         any_ff      <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) haz_ff[i] <= '0;
      end else begin
         if (cmd.exec) begin
            ptr_ff  <= '0;
            left_ff <= '0;
            any_ff  <= 1'b0;
            unique case (req_ff.func)
               FUNC_ACCESS: begin
                  if (ok && !seen_ff[ix]) begin
                     seen_ff[ix] <= 1'b1;
                     if (count_ff < CW'(NUM_SLOTS)) count_ff <= count_ff + 1'b1;
                  end
               end
               FUNC_TRACK: if (ok) begin
                  tracked_ff[ix] <= 1'b1;
                  force_ff[ix]   <= 1'b0;
               end
               FUNC_FORGET: if (ok) begin
                  tracked_ff[ix] <= 1'b0;
                  force_ff[ix]   <= 1'b0;
                  haz_ff[ix]     <= '0;
               end
               FUNC_INVALIDATE: if (ok) begin
                  force_ff[ix] <= 1'b1;
                  haz_ff[ix]   <= '0;
               end
               FUNC_BATCH: begin
                  for (int i = 0; i < NUM_SLOTS; i++) begin
                     if (tracked_ff[i]) begin
                        force_ff[i] <= 1'b0;
                        haz_ff[i]   <= '{CONS_WR_STAGE, CONS_WR_ACCESS, 5'd0,
                                         REUSE_STAGE, REUSE_ACCESS};
                     end
                  end
               end
               default: ;
            endcase
         end
         if (cmd.count) begin
            ptr_ff <= at_last ? '0 : ptr_ff + 1'b1;
            if (emit) begin
               any_ff     <= 1'b1;
               left_ff    <= left_ff + 1'b1;
               emitted_ff <= emitted_ff + 1'b1;
            end else begin
               elided_ff  <= elided_ff + 1'b1;
            end
            if (cons) fallback_ff <= fallback_ff + 1'b1;
         end
         if (cmd.walk) begin
            ptr_ff      <= ptr_ff + 1'b1;
            haz_ff[wix] <= h_new;
            if (cons) force_ff[wix] <= 1'b0;
            if (emit) left_ff <= left_ff - 1'b1;
         end
         if (cmd.finish) begin
            seen_ff  <= '0;
            count_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (put || cmd.empty) rsp_valid_ff <= 1'b1;
      end
   end

   // counters are already the plan totals when the walk pass starts
   always_ff @(posedge clock) begin
      if (put) begin
         rsp_ff <= '{1'b1, ws, ss, sa, m.stage, m.access, cons,
                     left_ff == CW'(1), emitted_ff, fallback_ff, elided_ff};
      end else if (cmd.empty) begin
         rsp_ff <= '{1'b0, 4'd0, 5'd0, 7'd0, 5'd0, 7'd0, 1'b0,
                     1'b1, emitted_ff, fallback_ff, elided_ff};
      end
   end

   assign rsp_word  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   assign sts.eop       = req_ff.func == FUNC_ACCESS && req_ff.end_of_plan;
   assign sts.walk_last = at_last;
   assign sts.walk_none = count_ff == '0;
   assign sts.any       = any_ff;
   assign sts.rsp_busy  = rsp_valid_ff && !rsp_ready;
endmodule

// ----- src/bbhp_ctrl.sv -----
// ----------------------------------------------------------------------------
// bbhp_ctrl
// Sequencer: capture, execute, count and walk merged slots, close plan.
// ----------------------------------------------------------------------------
module bbhp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bbhp_pkg::sts_type sts,
   output bbhp_pkg::cmd_type cmd
);
   import bbhp_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_EXEC;
         ST_EXEC: state_in = sts.eop ? ST_COUNT : ST_IDLE;
         ST_COUNT: begin
            if (sts.walk_none) state_in = ST_CLOSE;
            else if (sts.walk_last) state_in = ST_WALK;
         end
         // hold the walk while the result register is still occupied
         ST_WALK: if (!sts.rsp_busy && sts.walk_last) state_in = ST_CLOSE;
         ST_CLOSE: if (sts.any || !sts.rsp_busy) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE:  begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_EXEC:  cmd.exec  = 1'b1;
         ST_COUNT: cmd.count = !sts.walk_none;
         ST_WALK:  cmd.walk  = !sts.rsp_busy;
         ST_CLOSE: begin
            cmd.empty  = !sts.any && !sts.rsp_busy;
            cmd.finish = sts.any || !sts.rsp_busy;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ----- src/buffer_barrier_hazard_planner.sv -----
// ----------------------------------------------------------------------------
// buffer_barrier_hazard_planner
// Per-slot buffer hazard tracker emitting at most one barrier per merged slot.
// ----------------------------------------------------------------------------
// A command or plain access is captured, then executed; a new request is taken
// only back in idle. End of plan: capture, execute, a count pass over the merged
// slots (no tally if nothing merged), a walk pass over them, a closing step;
// output stalls hold the walk. A barrier word is valid the cycle after its walk
// step, the empty word the cycle after the closing step.
// Reset: synchronous, active high; clears flags, hazard state, plan, counters.
module buffer_barrier_hazard_planner #(
   parameter int NUM_SLOTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bbhp_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bbhp_pkg::rsp_type rsp_word
);
   import bbhp_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // controller: sequences capture, execute and the two end-of-plan passes;
   // the count pass settles the counters so every word of a plan carries
   // the plan totals
   bbhp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: slot state, merge store, check logic, result word
   bbhp_datapath #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );
endmodule

// ----- src/bbhp_checker.sv -----
// ----------------------------------------------------------------------------
// bbhp_checker
// Port-level checks for the hazard planner.
// ----------------------------------------------------------------------------
module bbhp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input bbhp_pkg::rsp_type rsp_word
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word.out_slot))
      else $error("result word dropped");
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.has_barrier |-> rsp_word.last_of_plan)
      else $error("empty item not last");
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.has_barrier |-> rsp_word.out_slot == 4'd0 &&
      !rsp_word.is_conservative)
      else $error("empty item fields");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken back to back");
endmodule

bind buffer_barrier_hazard_planner bbhp_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
);

// ----- bench/tb_buffer_barrier_hazard_planner.sv -----
// ----------------------------------------------------------------------------
// tb_buffer_barrier_hazard_planner
// Self-checking bench: a directed table of commands and plans, then random plans
// and commands, scored against an in-bench hazard predictor and hand-written rows.
// ----------------------------------------------------------------------------
module tb_buffer_barrier_hazard_planner;
   timeunit 1ns;
   timeprecision 1ps;
   import bbhp_pkg::*;

   localparam int SLOTS      = 16;
   localparam int RAND_WORDS = 430;
   localparam int LIMIT      = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_word = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_word;

   buffer_barrier_hazard_planner #(.NUM_SLOTS(SLOTS)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // --------------------------------------------------------------------------
   // Hazard predictor: private copy of per-slot flags, hazard state, the open
   // plan and the wrapping statistics counters.
   // --------------------------------------------------------------------------
   logic       trk [SLOTS];
   logic       frc [SLOTS];
   hazard_type hz  [SLOTS];
   scope_type  mscope [SLOTS];
   logic       mseen  [SLOTS];
   logic [3:0] order  [SLOTS];
   int         mcount;
   logic [31:0] n_emitted, n_fallback, n_elided;

   rsp_type barrier_q[$];   // expected result words, oldest first
   int      fail_count = 0;
   int      words_sent = 0;
   int      words_seen = 0;
   int      cycle_count = 0;

   task automatic clear_plan();
      for (int i = 0; i < SLOTS; i++) begin
         mseen[i] = 1'b0;
         mscope[i] = '0;
         order[i] = '0;
      end
      mcount = 0;
   endtask

   task automatic clear_state();
      for (int i = 0; i < SLOTS; i++) begin
         trk[i] = 1'b0;
         frc[i] = 1'b0;
         hz[i] = '0;
      end
      clear_plan();
      n_emitted = '0;
      n_fallback = '0;
      n_elided = '0;
   endtask

   // scope of one use code: stage, access, write flag
   function automatic scope_type scope_of(logic [2:0] u);
      scope_type s;
      s = '0;
      case (u)
         3'd0: begin s.stage = 5'h01; s.access = 7'h01; end
         3'd1: begin s.stage = 5'h01; s.access = 7'h02; s.wr = 1'b1; end
         3'd2: begin s.stage = 5'h01; s.access = 7'h03; s.wr = 1'b1; end
         3'd3: begin s.stage = 5'h02; s.access = 7'h04; end
         3'd4: begin s.stage = 5'h02; s.access = 7'h08; s.wr = 1'b1; end
         3'd5: begin s.stage = 5'h04; s.access = 7'h10; end
         3'd6: begin s.stage = 5'h08; s.access = 7'h20; end
         default: begin s.stage = 5'h10; s.access = 7'h40; end
      endcase
      return s;
   endfunction

   // walk the merged slots in first-seen order; queue the plan's words
   task automatic close_plan();
      rsp_type    words[$];
      rsp_type    it;
      int         s;
      scope_type  m;
      logic       has_wr, emit;
      logic [4:0] ss;
      logic [6:0] sa;
      for (int k = 0; k < mcount; k++) begin
         s = order[k];
         m = mscope[s];
         it = '0;
         it.has_barrier = 1'b1;
         it.out_slot = s[3:0];
         it.dst_stage = m.stage;
         it.dst_access = m.access;
         if (!trk[s] || frc[s]) begin
            // untracked or invalidated: conservative writer as source
            it.src_stage = CONS_WR_STAGE;
            it.src_access = CONS_WR_ACCESS;
            it.is_conservative = 1'b1;
            words = {words, it};
            n_emitted++;
            n_fallback++;
            frc[s] = 1'b0;
            hz[s] = '0;
            if (trk[s]) begin
               if (m.wr) begin
                  hz[s].wr_stage = m.stage;
                  hz[s].wr_access = m.access;
               end else begin
                  hz[s].wr_stage = CONS_WR_STAGE;
                  hz[s].wr_access = CONS_WR_ACCESS;
                  hz[s].vis_stage = m.stage;
                  hz[s].vis_access = m.access;
                  hz[s].rd_stages = m.stage;
               end
            end
         end else begin
            has_wr = (hz[s].wr_stage != 0) || (hz[s].wr_access != 0);
            emit = 1'b0;
            ss = '0;
            sa = '0;
            if (!m.wr) begin
               // read: barrier only if the prior write is not yet visible
               if (has_wr && (((m.stage & ~hz[s].vis_stage) != 0) ||
                              ((m.access & ~hz[s].vis_access) != 0))) begin
                  emit = 1'b1;
                  ss = hz[s].wr_stage;
                  sa = hz[s].wr_access;
                  hz[s].vis_stage |= m.stage;
                  hz[s].vis_access |= m.access;
               end
               hz[s].rd_stages |= m.stage;
            end else begin
               if (has_wr) begin
                  emit = 1'b1;
                  ss = hz[s].wr_stage | hz[s].rd_stages;
                  sa = hz[s].wr_access;
               end else if (hz[s].rd_stages != 0) begin
                  emit = 1'b1;
                  ss = hz[s].rd_stages;
               end
               hz[s] = '0;
               hz[s].wr_stage = m.stage;
               hz[s].wr_access = m.access;
            end
            if (emit) begin
               it.src_stage = ss;
               it.src_access = sa;
               words = {words, it};
               n_emitted++;
            end else begin
               n_elided++;
            end
         end
      end
      if (words.size() == 0) words = {words, rsp_type'('0)};
      foreach (words[i]) begin
         words[i].emit_total = n_emitted;
         words[i].cons_total = n_fallback;
         words[i].elide_total = n_elided;
         words[i].last_of_plan = (i == words.size() - 1);
         barrier_q = {barrier_q, words[i]};
      end
      clear_plan();
   endtask

   task automatic predict_word(req_type w);
      int s;
      s = w.buffer_index;
      case (w.func)
         FUNC_ACCESS: begin
            if (!mseen[s]) begin
               mseen[s] = 1'b1;
               mscope[s] = scope_of(w.use_req);
               order[mcount] = s[3:0];
               mcount++;
            end else begin
               mscope[s] = mscope[s] | scope_of(w.use_req);
            end
            if (w.end_of_plan) close_plan();
         end
         FUNC_TRACK: begin
            trk[s] = 1'b1;
            frc[s] = 1'b0;
         end
         FUNC_FORGET: begin
            trk[s] = 1'b0;
            frc[s] = 1'b0;
            hz[s] = '0;
         end
         FUNC_INVALIDATE: begin
            frc[s] = 1'b1;
            hz[s] = '0;
         end
         FUNC_BATCH: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (trk[i]) begin
                  frc[i] = 1'b0;
                  hz[i] = '0;
                  hz[i].wr_stage = CONS_WR_STAGE;
                  hz[i].wr_access = CONS_WR_ACCESS;
                  hz[i].vis_stage = REUSE_STAGE;
                  hz[i].vis_access = REUSE_ACCESS;
               end
            end
         end
         FUNC_CLEAR: clear_state();
         default: ;  // unused codes do nothing
      endcase
   endtask

   // --------------------------------------------------------------------------
   // Sender side
   // --------------------------------------------------------------------------
   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one word and hold it until taken. Typed rows replace the
   // predicted words with the hand-written one (state still updated).
   task automatic send_word(req_type w, bit typed, rsp_type want);
      int depth, gap;
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (!req_ready);
      depth = barrier_q.size();
      predict_word(w);
      if (typed) begin
         while (barrier_q.size() > depth) void'(barrier_q.pop_back());
         barrier_q = {barrier_q, want};
      end
      words_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic req_type mk(func_type f, int slot, int u, bit eop);
      req_type w;
      w.func = f;
      w.buffer_index = slot[3:0];
      w.use_req = u[2:0];
      w.end_of_plan = eop;
      return w;
   endfunction

   task automatic send_plain(req_type w);
      send_word(w, 1'b0, rsp_type'('0));
   endtask

   // a plan of random accesses; now and then a command lands mid-plan
   task automatic send_plan(int len, bit wide);
      int slot;
      func_type f;
      for (int i = 0; i < len; i++) begin
         slot = wide ? i : $urandom_range(0, SLOTS - 1);
         if (!wide && $urandom_range(0, 3) == 0) slot = $urandom_range(0, 3);
         send_plain(mk(FUNC_ACCESS, slot, $urandom_range(0, 7), i == len - 1));
         if (i != len - 1 && $urandom_range(0, 19) == 0) begin
            f = func_type'($urandom_range(FUNC_TRACK, FUNC_BATCH));
            send_plain(mk(f, $urandom_range(0, SLOTS - 1), $urandom_range(0, 7),
                          1'($urandom_range(0, 1))));
         end
      end
   endtask

   task automatic drain();
      while (barrier_q.size() != 0) @(posedge clock);
   endtask

   typedef struct {
      req_type w;
      bit      typed;
      rsp_type want;
   } row_type;

   row_type table_rows[$];

   task automatic add_row(req_type w, bit typed = 1'b0, rsp_type want = '0);
      row_type r;
      r.w = w;
      r.typed = typed;
      r.want = want;
      table_rows = {table_rows, r};
   endtask

   initial begin
      int r;
      int mark;
      clear_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table
      // untracked slot: conservative barrier straight after reset
      add_row(mk(FUNC_ACCESS, 0, 0, 1), 1'b1,
              '{1'b1, 4'd0, CONS_WR_STAGE, CONS_WR_ACCESS, 5'h01, 7'h01,
                1'b1, 1'b1, 32'd1, 32'd1, 32'd0});
      add_row(mk(FUNC_TRACK, 0, 0, 0));
      add_row(mk(FUNC_TRACK, 15, 7, 1));          // eop ignored on a command
      // tracked, empty state, read: elided, empty word
      add_row(mk(FUNC_ACCESS, 0, 7, 1), 1'b1,
              '{1'b0, 4'd0, 5'd0, 7'd0, 5'd0, 7'd0, 1'b0, 1'b1,
                32'd1, 32'd1, 32'd1});
      add_row(mk(FUNC_ACCESS, 15, 1, 0));         // merged write on one slot
      add_row(mk(FUNC_ACCESS, 15, 2, 0));
      add_row(mk(FUNC_ACCESS, 0, 4, 0));
      add_row(mk(FUNC_ACCESS, 3, 6, 1));
      add_row(mk(FUNC_ACCESS, 15, 3, 1));         // read after write
      add_row(mk(FUNC_ACCESS, 15, 3, 1));         // already visible
      add_row(mk(FUNC_INVALIDATE, 0, 0, 0));
      add_row(mk(FUNC_ACCESS, 0, 5, 1));          // forced slot
      add_row(mk(FUNC_BATCH, 0, 0, 0));
      add_row(mk(FUNC_ACCESS, 15, 5, 1));         // inside reuse scope
      add_row(mk(FUNC_ACCESS, 0, 7, 1));          // outside reuse scope
      add_row(mk(FUNC_ACCESS, 15, 4, 0));
      add_row(mk(FUNC_FORGET, 15, 0, 0));         // command inside a plan
      add_row(mk(FUNC_ACCESS, 0, 6, 1));
      add_row(req_type'{3'd6, 4'd9, 3'd5, 1'b1}); // unused codes
      add_row(req_type'{3'd7, 4'd6, 3'd2, 1'b0});
      add_row(mk(FUNC_CLEAR, 0, 0, 0));
      add_row(mk(FUNC_ACCESS, 5, 0, 1), 1'b1,
              '{1'b1, 4'd5, CONS_WR_STAGE, CONS_WR_ACCESS, 5'h01, 7'h01,
                1'b1, 1'b1, 32'd1, 32'd1, 32'd0});
      foreach (table_rows[i]) send_word(table_rows[i].w, table_rows[i].typed,
                                        table_rows[i].want);

      // every slot in one plan, with the even slots tracked
      for (int s = 0; s < SLOTS; s += 2) send_plain(mk(FUNC_TRACK, s, 0, 0));
      send_plan(SLOTS, 1'b1);

      // pause until everything is out
      req_valid <= 1'b0;
      drain();

      mark = words_sent;
      while (words_sent - mark < RAND_WORDS) begin
         r = $urandom_range(0, 99);
         if (r < 58)      send_plan($urandom_range(1, 6), 1'b0);
         else if (r < 60) send_plan(SLOTS, 1'b1);
         else if (r < 74) send_plain(mk(FUNC_TRACK, $urandom_range(0, SLOTS - 1),
                                        $urandom_range(0, 7), 1'($urandom_range(0, 1))));
         else if (r < 79) send_plain(mk(FUNC_FORGET, $urandom_range(0, SLOTS - 1),
                                        $urandom_range(0, 7), 1'($urandom_range(0, 1))));
         else if (r < 85) send_plain(mk(FUNC_INVALIDATE, $urandom_range(0, SLOTS - 1),
                                        $urandom_range(0, 7), 1'($urandom_range(0, 1))));
         else if (r < 90) send_plain(mk(FUNC_BATCH, $urandom_range(0, SLOTS - 1),
                                        $urandom_range(0, 7), 1'($urandom_range(0, 1))));
         else if (r < 92) send_plain(mk(FUNC_CLEAR, $urandom_range(0, SLOTS - 1),
                                        $urandom_range(0, 7), 1'($urandom_range(0, 1))));
         else send_plain(req_type'{3'($urandom_range(6, 7)), 4'($urandom_range(0, 15)),
                                    3'($urandom_range(0, 7)), 1'($urandom_range(0, 1))});
      end

      req_valid <= 1'b0;
      drain();
      repeat (80) @(posedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // --------------------------------------------------------------------------
   // Receiver side: random stalls, one long hold-off to back the block up
   // --------------------------------------------------------------------------
   task automatic check_word(rsp_type got);
      rsp_type e;
      if (barrier_q.size() == 0) begin
         $error("unexpected result word %h", got);
         fail_count++;
         return;
      end
      e = barrier_q.pop_front();
      if (got != e) fail_count++;
      if (got.has_barrier != e.has_barrier)
         $error("has_barrier exp %0d got %0d", e.has_barrier, got.has_barrier);
      if (got.out_slot != e.out_slot)
         $error("out_slot exp %0d got %0d", e.out_slot, got.out_slot);
      if (got.src_stage != e.src_stage)
         $error("src_stage exp %h got %h", e.src_stage, got.src_stage);
      if (got.src_access != e.src_access)
         $error("src_access exp %h got %h", e.src_access, got.src_access);
      if (got.dst_stage != e.dst_stage)
         $error("dst_stage exp %h got %h", e.dst_stage, got.dst_stage);
      if (got.dst_access != e.dst_access)
         $error("dst_access exp %h got %h", e.dst_access, got.dst_access);
      if (got.is_conservative != e.is_conservative)
         $error("is_conservative exp %0d got %0d", e.is_conservative, got.is_conservative);
      if (got.last_of_plan != e.last_of_plan)
         $error("last_of_plan exp %0d got %0d", e.last_of_plan, got.last_of_plan);
      if (got.emit_total != e.emit_total)
         $error("emit_total exp %0d got %0d", e.emit_total, got.emit_total);
      if (got.cons_total != e.cons_total)
         $error("cons_total exp %0d got %0d", e.cons_total, got.cons_total);
      if (got.elide_total != e.elide_total)
         $error("elide_total exp %0d got %0d", e.elide_total, got.elide_total);
   endtask

   initial begin
      int  stall_left;
      bit  held;
      stall_left = 0;
      held = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            check_word(rsp_word);
            words_seen++;
         end
         if (!held && words_seen >= 60) begin
            // long hold-off while the sender keeps offering
            held = 1'b1;
            stall_left = 400;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

endmodule

// ----- files.f -----
src/bbhp_pkg.sv
src/bbhp_datapath.sv
src/bbhp_ctrl.sv
src/buffer_barrier_hazard_planner.sv
src/bbhp_checker.sv
bench/tb_buffer_barrier_hazard_planner.sv
